// File: rtl/lpim_pkg.sv
// Package for the linear-probe ID map: payload structs, status codes,
// sequencer states and table constants. No dependencies.
package lpim_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned REC_W           = 32;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam logic [31:0] HASH_MUL        = 32'd2654435761;

  localparam logic [1:0] STAT_HIT      = 2'd0;
  localparam logic [1:0] STAT_MISS     = 2'd1;
  localparam logic [1:0] STAT_INSERTED = 2'd2;
  localparam logic [1:0] STAT_REFUSED  = 2'd3;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  localparam logic REG_KEY_LIMIT = 1'b0;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] lookup_key;
    logic [REC_W-1:0] record_in;
  } lpim_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [REC_W-1:0] record_out;
    logic [POS_W-1:0] slot_position;
  } lpim_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP
  } lpim_state_t;

endpackage

// File: rtl/lpim_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lpim_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/linear_probe_id_map.sv
// Top level of the linear-probe ID map: sequencer, hash, probe compare, APB register.
// Depends on lpim_pkg and lpim_ram.
//
// channel   ports                        handshake
// -------   --------------------------   --------------------------------------
// input     start, busy, in_req          transfer when start & !busy
// result    out_valid, out_res           one-cycle strobe, no backpressure
// config    psel/penable/pwrite/paddr    write when psel & penable & pwrite
//
// Requests rejected by key or fill checks are answered straight from idle. Others
// pass through the accepting cycle, a hash state and, per probe, a key/record RAM
// read then a compare; the single RAM port paces the probe loop.
// After reset the key table is swept to empty slot by slot, with
// busy high; register writes are taken during the sweep.
// The result is registered; busy drops in the cycle the strobe is shown.
module linear_probe_id_map
  import lpim_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lpim_req_t             in_req,
  output logic                  out_valid,
  output lpim_res_t             out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] MUL_LO   = HASH_MUL[IDX_W-1:0];
  localparam logic [IDX_W-1:0] HALF     = IDX_W'(TABLE_SLOTS / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  lpim_state_t      state_r, state_nxt;
  logic [31:0]      key_limit_r;
  lpim_req_t        req_r, req_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;
  lpim_res_t        out_res_r, out_res_nxt;

  logic             key_ok;
  logic [IDX_W-1:0] hash_c;
  logic             ram_key_we, ram_rec_we;
  logic [IDX_W-1:0] ram_addr;
  logic [KEY_W-1:0] ram_key_wdata;
  logic [KEY_W-1:0] key_rd;
  logic [REC_W-1:0] rec_rd;
  logic             cfg_wr;

  lpim_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (ram_key_we),
    .addr  (ram_addr),
    .wdata (ram_key_wdata),
    .rdata (key_rd)
  );

  lpim_ram #(.WIDTH(REC_W), .DEPTH(TABLE_SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (ram_rec_we),
    .addr  (ram_addr),
    .wdata (req_r.record_in),
    .rdata (rec_rd)
  );

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_KEY_LIMIT) ? key_limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= 32'd0;
    end else if (cfg_wr && paddr[2] == REG_KEY_LIMIT) begin
      key_limit_r <= pwdata;
    end
  end

  // Only the low index bits of the product matter
  assign hash_c = req_r.lookup_key[IDX_W-1:0] * MUL_LO;
  assign key_ok = (in_req.lookup_key != '0) && (in_req.lookup_key <= key_limit_r);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ram_key_we    = 1'b0;
    ram_rec_we    = 1'b0;
    ram_addr      = pos_r;
    ram_key_wdata = req_r.lookup_key;

    unique case (state_r)
      S_CLEAR: begin
        ram_addr      = cnt_r;
        ram_key_we    = 1'b1;
        ram_key_wdata = '0;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          if (!key_ok || (in_req.req_type == REQ_INSERT && occ_r >= HALF)) begin
            out_valid_nxt = 1'b1;
            out_res_nxt.status = (in_req.req_type == REQ_INSERT) ? STAT_REFUSED
                                                                 : STAT_MISS;
            out_res_nxt.record_out    = '0;
            out_res_nxt.slot_position = '0;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        pos_nxt   = hash_c;
        cnt_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        out_res_nxt.record_out    = '0;
        out_res_nxt.slot_position = '0;
        if (req_r.req_type == REQ_INSERT) begin
          if (key_rd == '0) begin
            ram_key_we    = 1'b1;
            ram_rec_we    = 1'b1;
            occ_nxt       = occ_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_res_nxt.status        = STAT_INSERTED;
            out_res_nxt.slot_position = POS_W'(pos_r);
            state_nxt     = S_IDLE;
          end else if (cnt_r == LAST_IDX) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = STAT_REFUSED;
            state_nxt          = S_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          if (key_rd == '0 || (key_rd == req_r.lookup_key && rec_rd == '0)
              || (key_rd != req_r.lookup_key && cnt_r == LAST_IDX)) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = STAT_MISS;
            state_nxt          = S_IDLE;
          end else if (key_rd == req_r.lookup_key) begin
            out_valid_nxt             = 1'b1;
            out_res_nxt.status        = STAT_HIT;
            out_res_nxt.record_out    = rec_rd;
            out_res_nxt.slot_position = POS_W'(pos_r);
            state_nxt                 = S_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pos_r     <= pos_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
